// ----- design/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by every module of the block.
package cbm_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PADDR_W    = 23;
  localparam int unsigned ROM_BANK_W = 9;
  localparam int unsigned RAM_BANK_W = 4;
  localparam int unsigned MAPPER_W   = 3;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned RSIZE_W    = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [MAPPER_W-1:0] MAPPER_NONE = 3'd0;
  localparam logic [MAPPER_W-1:0] MAPPER_ROM  = 3'd1;
  localparam logic [MAPPER_W-1:0] MAPPER_MBC1 = 3'd2;
  localparam logic [MAPPER_W-1:0] MAPPER_MBC2 = 3'd3;
  localparam logic [MAPPER_W-1:0] MAPPER_MBC3 = 3'd4;
  localparam logic [MAPPER_W-1:0] MAPPER_MBC5 = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_RAM_SIZE   = 2'd2;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'b1010;

  typedef struct packed {
    logic [MAPPER_W-1:0] mapper_type;
    logic [COUNT_W-1:0]  rom_bank_count;
    logic [RSIZE_W-1:0]  ext_ram_size;
  } cfg_t;

  typedef struct packed {
    logic [4:0]            low_bank_select;
    logic [1:0]            upper_bank_select;
    logic                  advanced_mode;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
  } bank_state_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic               rom_read;
    logic               ram_read;
    logic               ram_write;
    logic [PADDR_W-1:0] physical_address;
    logic               open_bus;
    logic               pad_high_nibble;
  } result_t;

endpackage

// ----- design/cbm_regs.sv -----
// Configuration registers and mapper bank registers.
// Depends on cbm_pkg.
module cbm_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           upd_en,
  input  cbm_pkg::item_t                 item,
  output cbm_pkg::cfg_t                  cfg,
  output cbm_pkg::bank_state_t           bank
);

  cbm_pkg::cfg_t        cfg_r;
  cbm_pkg::bank_state_t bank_r, bank_nxt;
  logic [cbm_pkg::DATA_W-1:0] val;
  logic [2:0]                 a_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_type    <= cbm_pkg::MAPPER_NONE;
      cfg_r.rom_bank_count <= 10'd2;
      cfg_r.ext_ram_size   <= 18'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::CFG_MAPPER_TYPE:    cfg_r.mapper_type    <= cfg_data[cbm_pkg::MAPPER_W-1:0];
        cbm_pkg::CFG_ROM_BANK_COUNT: cfg_r.rom_bank_count <= cfg_data[cbm_pkg::COUNT_W-1:0];
        cbm_pkg::CFG_EXT_RAM_SIZE:   cfg_r.ext_ram_size   <= cfg_data[cbm_pkg::RSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // address bits 14:12 select the register window below 0x8000
  assign val  = item.write_data;
  assign a_hi = item.address[14:12];

  always_comb begin
    bank_nxt = bank_r;
    if (upd_en) begin
      case (cfg_r.mapper_type)
        cbm_pkg::MAPPER_MBC1: begin
          case (a_hi[2:1])
            2'b00:   bank_nxt.ram_enabled       = (val[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            2'b01:   bank_nxt.low_bank_select   = val[4:0];
            2'b10:   bank_nxt.upper_bank_select = val[1:0];
            default: bank_nxt.advanced_mode     = val[0];
          endcase
        end
        cbm_pkg::MAPPER_MBC2: begin
          if (!a_hi[2]) begin
            if (item.address[8]) bank_nxt.rom_bank = {5'd0, val[3:0]};
            else bank_nxt.ram_enabled = (val[3:0] == cbm_pkg::RAM_ENABLE_KEY);
          end
        end
        cbm_pkg::MAPPER_MBC3: begin
          if (a_hi[2:1] == 2'b01) begin
            bank_nxt.rom_bank = {1'b0, val};
          end else if (a_hi[2:1] == 2'b10 && val[7:3] == 5'd0) begin
            bank_nxt.ram_bank = val[cbm_pkg::RAM_BANK_W-1:0];
          end
        end
        cbm_pkg::MAPPER_MBC5: begin
          if (a_hi == 3'b010) begin
            bank_nxt.rom_bank = {bank_r.rom_bank[8], val};
          end else if (a_hi == 3'b011) begin
            bank_nxt.rom_bank = {val[0], bank_r.rom_bank[7:0]};
          end else if (a_hi[2:1] == 2'b10) begin
            bank_nxt.ram_bank = val[cbm_pkg::RAM_BANK_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= '0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  assign cfg  = cfg_r;
  assign bank = bank_r;

endmodule

// ----- design/cbm_xlate.sv -----
// Address translation: ROM/RAM strobes, physical address and read flags.
// Depends on cbm_pkg.
module cbm_xlate (
  input  cbm_pkg::item_t       item,
  input  cbm_pkg::cfg_t        cfg,
  input  cbm_pkg::bank_state_t bank,
  output cbm_pkg::result_t     res
);

  logic [cbm_pkg::COUNT_W-1:0]    count_m1;
  logic [cbm_pkg::ROM_BANK_W-1:0] rom_mask;
  logic [cbm_pkg::ROM_BANK_W-1:0] rbank;
  logic [4:0]                     low_sel;
  logic [cbm_pkg::ROM_BANK_W-1:0] rom_bank_nz;
  logic [cbm_pkg::RSIZE_W-1:0]    size_m1;
  logic [14:0]                    mbc1_off;
  logic [cbm_pkg::PADDR_W-1:0]    ram_pa;
  logic                           ram_ok;
  logic                           pad;
  logic                           hi;
  logic                           rom_space;
  logic                           ram_space;
  logic [12:0]                    off13;

  assign count_m1    = cfg.rom_bank_count - 10'd1;
  assign rom_mask    = count_m1[cbm_pkg::ROM_BANK_W-1:0];
  assign size_m1     = cfg.ext_ram_size - 18'd1;
  assign low_sel     = (bank.low_bank_select == 5'd0) ? 5'd1 : bank.low_bank_select;
  assign rom_bank_nz = (bank.rom_bank == '0) ? 9'd1 : bank.rom_bank;
  assign hi          = item.address[14];
  assign off13       = item.address[12:0];
  assign rom_space   = !item.address[15];
  assign ram_space   = item.address[15:13] == 3'b101;
  assign mbc1_off    = ({bank.advanced_mode ? bank.upper_bank_select : 2'b00, off13})
                       & size_m1[14:0];

  always_comb begin
    case (cfg.mapper_type)
      cbm_pkg::MAPPER_MBC1: begin
        if (!hi) rbank = bank.advanced_mode ? {2'b00, bank.upper_bank_select, 5'd0} : '0;
        else rbank = {2'b00, bank.upper_bank_select, low_sel};
        rbank = rbank & rom_mask;
      end
      cbm_pkg::MAPPER_MBC2,
      cbm_pkg::MAPPER_MBC3: rbank = hi ? (rom_bank_nz & rom_mask) : '0;
      cbm_pkg::MAPPER_MBC5: rbank = hi ? (bank.rom_bank & rom_mask) : '0;
      default:              rbank = {8'd0, hi};
    endcase
  end

  always_comb begin
    ram_ok = 1'b1;
    pad    = 1'b0;
    ram_pa = {10'd0, off13};
    case (cfg.mapper_type)
      cbm_pkg::MAPPER_NONE: ram_ok = 1'b0;
      cbm_pkg::MAPPER_MBC1: begin
        ram_ok = bank.ram_enabled;
        ram_pa = {8'd0, mbc1_off};
      end
      cbm_pkg::MAPPER_MBC2: begin
        ram_ok = bank.ram_enabled;
        pad    = 1'b1;
        ram_pa = {14'd0, off13[8:0]};
      end
      cbm_pkg::MAPPER_MBC3,
      cbm_pkg::MAPPER_MBC5: ram_pa = {6'd0, bank.ram_bank, off13};
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    if (rom_space) begin
      if (!item.action) begin
        if (cfg.mapper_type == cbm_pkg::MAPPER_NONE) begin
          res.open_bus = 1'b1;
        end else begin
          res.rom_read         = 1'b1;
          res.physical_address = {rbank, item.address[13:0]};
        end
      end
    end else if (ram_space) begin
      if (ram_ok) begin
        res.physical_address = ram_pa;
        if (item.action) begin
          res.ram_write = 1'b1;
        end else begin
          res.ram_read        = 1'b1;
          res.pad_high_nibble = pad;
        end
      end else if (!item.action) begin
        res.open_bus = 1'b1;
      end
    end
  end

endmodule

// ----- design/cartridge_bank_mapper.sv -----
// Cartridge bank mapper: input register, bank registers, translation, result register.
// Depends on cbm_pkg, cbm_regs and cbm_xlate.
//
// Takes one bus access per cycle unless out_ready stalls the output, and gives
// exactly one result item for each, in order. An item passes an input register, then
// the result register, which holds it while out_ready is low; throughput is one item
// per cycle when not stalled, set by the single translation stage between those
// registers. Bank register writes take effect for the next item. in_ready follows
// out_ready while both registers hold items. Configuration is written through cfg_we,
// cfg_index and cfg_data and must only change while no item is in flight.
module cartridge_bank_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [cbm_pkg::ADDR_W-1:0]          in_address,
  input  logic [cbm_pkg::DATA_W-1:0]          in_write_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_rom_read,
  output logic                                out_ram_read,
  output logic                                out_ram_write,
  output logic [cbm_pkg::PADDR_W-1:0]         out_physical_address,
  output logic                                out_open_bus,
  output logic                                out_pad_high_nibble
);

  cbm_pkg::item_t       item_r;
  logic                 item_vld_r;
  cbm_pkg::result_t     res_r, res_nxt;
  logic                 res_vld_r;
  logic                 adv;
  logic                 upd_en;
  cbm_pkg::cfg_t        cfg;
  cbm_pkg::bank_state_t bank;

  assign adv      = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || adv;
  assign upd_en   = adv && item_r.action && !item_r.address[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{action: in_action, address: in_address, write_data: in_write_data};
    end
  end

  cbm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd_en    (upd_en),
    .item      (item_r),
    .cfg       (cfg),
    .bank      (bank)
  );

  cbm_xlate u_xlate (
    .item (item_r),
    .cfg  (cfg),
    .bank (bank),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = res_vld_r;
  assign out_rom_read         = res_r.rom_read;
  assign out_ram_read         = res_r.ram_read;
  assign out_ram_write        = res_r.ram_write;
  assign out_physical_address = res_r.physical_address;
  assign out_open_bus         = res_r.open_bus;
  assign out_pad_high_nibble  = res_r.pad_high_nibble;

endmodule

// ----- design/cbm_checker.sv -----
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg.
module cbm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_rom_read,
  input logic                        out_ram_read,
  input logic                        out_ram_write,
  input logic [cbm_pkg::PADDR_W-1:0] out_physical_address,
  input logic                        out_open_bus,
  input logic                        out_pad_high_nibble
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_rom_read, out_ram_read, out_ram_write, out_open_bus}))
    else $error("more than one strobe");

  a_pad_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pad_high_nibble) |-> out_ram_read)
    else $error("padding without RAM read");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rom_read && !out_ram_read && !out_ram_write)
      |-> (out_physical_address == '0))
    else $error("address without strobe");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_physical_address)))
    else $error("stalled item changed");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_rom_read         (out_rom_read),
  .out_ram_read         (out_ram_read),
  .out_ram_write        (out_ram_write),
  .out_physical_address (out_physical_address),
  .out_open_bus         (out_open_bus),
  .out_pad_high_nibble  (out_pad_high_nibble)
);
